// ===== hw/rtl/hme_pkg.sv =====
// Package for the histogram mode estimator: sizes, reset values and the
// sequencer state type. No dependencies.
package hme_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int MAX_BINS_DEF    = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int NBINS_W     = 9;
    localparam int OUT_W       = 24;
    localparam int IN_W        = 16;
    localparam int NBINS_RESET = 16;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_BIN_RD,
        ST_BIN_MUL,
        ST_BIN_DIV,
        ST_BIN_WR,
        ST_MAX,
        ST_SEL,
        ST_FIN,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/histogram_mode_estimate_top.sv =====
// Histogram mode estimator top level: sample store, bin count memory and
// sequencer around one shared divider. Uses hme_pkg and hme_divider.
//
// Usage: samples arrive on the i_sample/i_last channel (valid/ready) and
// are stored at one per cycle. The sample marked last closes the set; the
// block then drops ready and works the set through:
//   clear pass     : zeroes the bin count memory, one entry a cycle
//   binning        : per stored sample a read, a divide and a count write,
//                    the divide skipped when all samples are equal; DW is
//                    the divider width, SAMPLE_BITS + 2*clog2(MAX_BINS+1)
//                    + FRAC_BITS + 3 bits (45 by default), one bit a cycle
//   max search     : one memory read a cycle
//   selection pass : counts the bins that hold the largest count
//   final divide   : on the shared divider
// The result then sits in the output register until o_valid is taken.
// Samples of the next set are accepted meanwhile; a stalled receiver holds
// back only the next result. Samples beyond MAX_SAMPLES in a set are dropped.
// i_cfg_we writes num_bins at any edge; write it only while idle.
// Reset is synchronous: it empties the set and sets num_bins to 16. The
// count memory needs no clearing after reset; each set clears it first.
module histogram_mode_estimate_top
    import hme_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int MAX_BINS    = MAX_BINS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [NBINS_W-1:0] i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [IN_W-1:0]    i_sample,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [OUT_W-1:0]   o_mode_value
);
    localparam int SW  = SAMPLE_BITS;
    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int CNW = $clog2(MAX_SAMPLES + 1);
    localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NW  = $clog2(MAX_BINS + 1);
    localparam int KW  = NW;
    localparam int SSW = 2 * NW + 1;
    localparam int DW  = SW + SSW + FRAC_BITS + 2;
    localparam int RW  = SW + FRAC_BITS + 1;

    // Configuration register
    logic [NBINS_W-1:0] r_nbins_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_nbins_cfg <= NBINS_W'(NBINS_RESET);
        else if (i_cfg_we) r_nbins_cfg <= i_cfg_wdata;
    end

    // Bins in use, clamped to 1..MAX_BINS
    logic [NW-1:0] w_n;
    always_comb begin
        if (r_nbins_cfg == '0) w_n = NW'(1);
        else if (32'(r_nbins_cfg) > 32'(MAX_BINS)) w_n = NW'(MAX_BINS);
        else w_n = NW'(r_nbins_cfg);
    end

    t_state r_state, n_state;

    logic [SW-1:0]  r_min, r_max;
    logic [CNW-1:0] r_count;
    logic [CNW-1:0] r_idx;
    logic [NW-1:0]  r_bin;
    logic [NW-1:0]  r_n;
    logic [SW-1:0]  r_range;
    logic [SW-1:0]  r_smp;
    logic [CNW-1:0] r_bcnt;
    logic [CNW-1:0] r_best;
    logic [KW-1:0]  r_k;
    logic [SSW-1:0] r_s;
    logic [BW-1:0]  r_wbin;
    logic           r_rd_v;
    logic [NW-1:0]  r_rd_bin;
    logic [OUT_W-1:0] r_out;
    logic           r_out_v;

    // Memories
    logic [SW-1:0]  mem_smp [MAX_SAMPLES];
    logic [CNW-1:0] mem_cnt [MAX_BINS];

    logic w_in_xfer;
    logic w_store;
    logic [SW-1:0] w_v;
    assign w_in_xfer = i_valid && o_ready;
    assign w_v       = SW'(i_sample);
    assign w_store   = w_in_xfer && (r_count < CNW'(MAX_SAMPLES));

    // Divider
    logic          w_div_start;
    logic [DW-1:0] w_div_num, w_div_den;
    logic          w_div_done;
    logic [DW-1:0] w_quo;

    hme_divider #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Divider operands: binning product (v - min) * N, final range * S and 2N * k
    logic [SW-1:0]        w_diff;
    logic [SW+NW-1:0]     w_bmul;
    logic [SSW-1:0]       w_s_eff;
    logic [KW-1:0]        w_k_eff;
    logic [SW+SSW-1:0]    w_fin_prod;
    logic [NW+KW:0]       w_fin_den;
    assign w_diff     = r_smp - r_min;
    assign w_bmul     = w_diff * r_n;
    assign w_s_eff    = (r_k == '0) ? SSW'(1) : r_s;
    assign w_k_eff    = (r_k == '0) ? KW'(1) : r_k;
    assign w_fin_prod = r_range * w_s_eff;
    assign w_fin_den  = {r_n, 1'b0} * w_k_eff;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:    if (w_in_xfer && i_last) n_state = ST_CLEAR;
            ST_CLEAR:   if (r_bin == r_n - 1'b1)
                            n_state = (r_count == '0) ? ST_MAX : ST_BIN_RD;
            ST_BIN_RD:  n_state = ST_BIN_MUL;
            ST_BIN_MUL: n_state = (r_range == '0) ? ST_BIN_WR : ST_BIN_DIV;
            ST_BIN_DIV: if (w_div_done) n_state = ST_BIN_WR;
            ST_BIN_WR:  n_state = (r_idx == r_count - 1'b1) ? ST_MAX : ST_BIN_RD;
            ST_MAX:     if (r_rd_v && r_rd_bin == r_n - 1'b1) n_state = ST_SEL;
            ST_SEL:     if (r_rd_v && r_rd_bin == r_n - 1'b1) n_state = ST_FIN;
            ST_FIN:     n_state = ST_DIV;
            ST_DIV:     if (w_div_done) n_state = ST_OUT;
            ST_OUT:     if (!r_out_v) n_state = ST_LOAD;
            default:    n_state = ST_LOAD;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_ready     = (r_state == ST_LOAD);
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        if (r_state == ST_BIN_MUL && r_range != '0) begin
            w_div_start = 1'b1;
            w_div_num   = DW'(w_bmul);
            w_div_den   = DW'(r_range);
        end else if (r_state == ST_FIN) begin
            w_div_start = 1'b1;
            w_div_num   = DW'(w_fin_prod) << FRAC_BITS;
            w_div_den   = DW'(w_fin_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_LOAD;
        else r_state <= n_state;
    end

    // Sample store write and read
    always_ff @(posedge i_clk) begin
        if (w_store) mem_smp[r_count[AW-1:0]] <= w_v;
        r_smp <= mem_smp[r_idx[AW-1:0]];
    end

    // Bin count memory: one write port, one registered read
    logic          w_cw;
    logic [BW-1:0] w_cw_a;
    logic [CNW-1:0] w_cw_d;
    logic [BW-1:0] w_cr_a;
    logic [DW-1:0] w_bin_q;
    always_comb begin
        w_cw   = 1'b0;
        w_cw_a = r_bin[BW-1:0];
        w_cw_d = '0;
        if (r_state == ST_CLEAR) w_cw = 1'b1;
        else if (r_state == ST_BIN_WR) begin
            w_cw   = 1'b1;
            w_cw_a = r_wbin;
            w_cw_d = r_bcnt + 1'b1;
        end
        w_bin_q = (r_range == '0) ? '0 : w_quo;
        w_cr_a  = r_bin[BW-1:0];
        if (r_state == ST_BIN_DIV || r_state == ST_BIN_MUL) begin
            if (w_bin_q >= DW'(r_n)) w_cr_a = BW'(r_n - 1'b1);
            else w_cr_a = w_bin_q[BW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw) mem_cnt[w_cw_a] <= w_cw_d;
        r_bcnt <= mem_cnt[w_cr_a];
    end

    // Datapath registers
    logic [2*NW:0] w_odd;
    assign w_odd = {r_rd_bin, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_out_v <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            if (o_valid && i_ready) r_out_v <= 1'b0;
            r_rd_v <= 1'b0;
            case (r_state)
                ST_LOAD: begin
                    if (w_store) begin
                        r_count <= r_count + 1'b1;
                        if (w_v < r_min) r_min <= w_v;
                        if (w_v > r_max) r_max <= w_v;
                    end
                    r_bin <= '0;
                    r_idx <= '0;
                    r_n   <= w_n;
                    if (w_in_xfer && i_last) r_range <=
                        (r_max >= r_min || w_store) ? SW'((w_store && w_v > r_max ? w_v : r_max)
                        - (w_store && w_v < r_min ? w_v : r_min)) : '0;
                end
                ST_CLEAR: begin
                    r_bin <= r_bin + 1'b1;
                    if (r_bin == r_n - 1'b1) begin
                        r_bin  <= '0;
                        r_best <= '0;
                        r_k    <= '0;
                        r_s    <= '0;
                    end
                end
                ST_BIN_MUL: begin
                    // Zero range puts the sample in bin 0 without a divide
                    if (r_range == '0) r_wbin <= '0;
                end
                ST_BIN_DIV: begin
                    if (w_div_done) r_wbin <= w_cr_a;
                end
                ST_BIN_WR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == r_count - 1'b1) begin
                        r_bin  <= '0;
                        r_best <= '0;
                        r_k    <= '0;
                        r_s    <= '0;
                    end
                end
                ST_MAX: begin
                    r_rd_v   <= (r_bin != r_n);
                    r_rd_bin <= r_bin;
                    if (r_bin != r_n) r_bin <= r_bin + 1'b1;
                    if (r_rd_v && r_bcnt > r_best) r_best <= r_bcnt;
                    if (r_rd_v && r_rd_bin == r_n - 1'b1) begin
                        r_bin  <= '0;
                        r_rd_v <= 1'b0;
                    end
                end
                ST_SEL: begin
                    r_rd_v   <= (r_bin != r_n);
                    r_rd_bin <= r_bin;
                    if (r_bin != r_n) r_bin <= r_bin + 1'b1;
                    if (r_rd_v && r_bcnt == r_best) begin
                        r_k <= r_k + 1'b1;
                        r_s <= r_s + SSW'(w_odd);
                    end
                    if (r_rd_v && r_rd_bin == r_n - 1'b1) begin
                        r_rd_v <= 1'b0;
                    end
                end
                ST_FIN: ;
                ST_DIV: ;
                ST_OUT: begin
                    // Load the result once the previous one has been taken
                    if (!r_out_v) begin
                        r_out   <= OUT_W'(RW'(r_min) << FRAC_BITS) + OUT_W'(w_quo);
                        r_out_v <= 1'b1;
                        r_count <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_out_v;
    assign o_mode_value = r_out;
endmodule

// ===== hw/rtl/hme_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by binning and the
// final estimate. Depends on nothing but its parameter.
module hme_divider #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_trial;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        w_trial = {r_rem, r_quo[W-1]};
        n_rem   = w_trial[W-1:0];
        n_quo   = {r_quo[W-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = W'(w_trial - {1'b0, r_den});
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
